/* design/lpt_pkg.sv */
// Shared constants and channel beat types for the IPv4 longest-prefix trie.
`timescale 1ns / 1ps

package lpt_pkg;

	// Address and prefix geometry
	localparam int ADDR_BITS       = 32;
	localparam int PLEN_W          = 6;
	localparam int REGION_IN_BITS  = 16;
	localparam int REGION_OUT_BITS = 16;
	localparam int WIDE_BITS       = 32;

	// Defaults for the top-level parameters
	localparam int NODE_COUNT_DEF  = 1024;
	localparam int REGION_BITS_DEF = 16;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic                      op;
		logic [ADDR_BITS-1:0]      address;
		logic [PLEN_W-1:0]         prefix_length;
		logic [REGION_IN_BITS-1:0] region_id;
	} req_t;

	typedef struct packed {
		logic                       found;
		logic [REGION_OUT_BITS-1:0] match_region;
		logic                       overflow;
	} rsp_t;

endpackage

/* design/lpt_ram.sv */
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write when enabled; read the old contents every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* design/ipv4_longest_prefix_trie.sv */
// Top level: binary trie for IPv4 longest-prefix match over a node memory.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+--------------------------------
//   req     | in        | req_valid / req_stall | op, address, prefix_length, id
//   rsp     | out       | rsp_valid / rsp_stall | found, match_region, overflow
//
// One item at a time. A walk covers 0 to 32 trie levels; an existing child
// is fetched with one node-memory read per level.
// The root node lives in flip-flops that reset clears; other nodes are written
// in full when allocated, so the node memory needs no clearing pass.
// A finished result waits in the output register while the next item is taken;
// the done cycle holds only while that register is still full and stalled.
`timescale 1ns / 1ps

module ipv4_longest_prefix_trie #(
	parameter int NODE_COUNT  = lpt_pkg::NODE_COUNT_DEF,
	parameter int REGION_BITS = lpt_pkg::REGION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lpt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lpt_pkg::rsp_t rsp
);

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int FREE_W = $clog2(NODE_COUNT + 1);
	localparam int NODE_W = 2 * IDX_W + 1 + REGION_BITS;
	localparam int ADDR_W = lpt_pkg::ADDR_BITS;
	localparam int PLEN_W = lpt_pkg::PLEN_W;
	localparam int WIDE_W = lpt_pkg::WIDE_BITS;

	typedef struct packed {
		logic [IDX_W-1:0]       child1;
		logic [IDX_W-1:0]       child0;
		logic                   is_end;
		logic [REGION_BITS-1:0] region;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                 state_q;
	node_t                  root_q;
	logic [FREE_W-1:0]      next_free_q;
	logic                   rsp_valid_q;
	lpt_pkg::rsp_t          rsp_q;
	lpt_pkg::rsp_t          res_q;

	logic                   op_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [PLEN_W-1:0]      level_q;
	logic [PLEN_W-1:0]      limit_q;
	logic [REGION_BITS-1:0] rid_q;
	logic                   hit_q;
	logic [REGION_BITS-1:0] hit_reg_q;
	node_t                  node_q;
	logic                   use_rd_q;
	logic [IDX_W-1:0]       cur_idx_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_addr;
	logic [NODE_W-1:0]      ram_rdata;

	node_t                  cur;
	node_t                  wr_node;
	logic [IDX_W-1:0]       nxt;
	logic [IDX_W-1:0]       new_idx;
	logic                   at_limit;
	logic                   pool_full;
	logic                   hit_n;
	logic [REGION_BITS-1:0] reg_n;
	logic [WIDE_W-1:0]      reg_wide;
	logic [WIDE_W-1:0]      rid_wide;
	logic [PLEN_W-1:0]      plen_clamped;
	logic                   do_read;
	logic                   do_write;
	logic                   do_alloc;
	logic                   finish;
	lpt_pkg::rsp_t          res_n;
	logic                   req_take;
	logic                   rsp_load;

	// Node memory; index 0 stays unused since the root lives in flops
	lpt_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_node),
		.rdata(ram_rdata)
	);

	// Current node: fresh read data, or the root / a newly allocated node
	assign cur       = use_rd_q ? node_t'(ram_rdata) : node_q;
	assign nxt       = addr_q[ADDR_W-1] ? cur.child1 : cur.child0;
	assign new_idx   = next_free_q[IDX_W-1:0];
	assign at_limit  = (level_q == limit_q);
	assign pool_full = (next_free_q == FREE_W'(NODE_COUNT));
	assign hit_n     = hit_q | cur.is_end;
	assign reg_n     = cur.is_end ? cur.region : hit_reg_q;
	assign reg_wide  = WIDE_W'(reg_n);
	assign rid_wide  = WIDE_W'(req.region_id);

	// Clamp prefix length to the address width
	assign plen_clamped = (req.prefix_length > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W)
		: req.prefix_length;

	// Decide one trie level: descend, allocate, mark or finish
	always_comb begin
		do_read  = 1'b0;
		do_write = 1'b0;
		do_alloc = 1'b0;
		finish   = 1'b0;
		wr_node  = cur;
		res_n    = '0;
		if (state_q == ST_WALK) begin
			if (op_q == lpt_pkg::OP_LOOKUP) begin
				if (at_limit || nxt == '0) begin
					finish             = 1'b1;
					res_n.found        = hit_n;
					res_n.match_region = reg_wide[lpt_pkg::REGION_OUT_BITS-1:0];
				end else begin
					do_read = 1'b1;
				end
			end else if (at_limit) begin
				do_write       = 1'b1;
				finish         = 1'b1;
				wr_node.is_end = 1'b1;
				wr_node.region = rid_q;
			end else if (nxt != '0) begin
				do_read = 1'b1;
			end else if (pool_full) begin
				// Write back as is: a fresh node must still land in memory
				do_write       = 1'b1;
				finish         = 1'b1;
				res_n.overflow = 1'b1;
			end else begin
				do_write = 1'b1;
				do_alloc = 1'b1;
				if (addr_q[ADDR_W-1]) begin
					wr_node.child1 = new_idx;
				end else begin
					wr_node.child0 = new_idx;
				end
			end
		end
	end

	// Writes go to the node being left; reads fetch the child. Never both.
	assign ram_we   = do_write && (cur_idx_q != '0);
	assign ram_addr = do_write ? cur_idx_q : nxt;

	assign req_take  = (state_q == ST_IDLE) && req_valid;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Control state, root node and free pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_q      <= '0;
			next_free_q <= FREE_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_write && cur_idx_q == '0) begin
				root_q <= wr_node;
			end
			if (do_alloc) begin
				next_free_q <= next_free_q + FREE_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers and result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q      <= req.op;
			addr_q    <= req.address;
			limit_q   <= (req.op == lpt_pkg::OP_LOOKUP) ? PLEN_W'(ADDR_W) : plen_clamped;
			rid_q     <= rid_wide[REGION_BITS-1:0];
			level_q   <= '0;
			hit_q     <= 1'b0;
			hit_reg_q <= '0;
			node_q    <= root_q;
			use_rd_q  <= 1'b0;
			cur_idx_q <= '0;
		end
		if (do_read) begin
			use_rd_q  <= 1'b1;
			cur_idx_q <= nxt;
			level_q   <= level_q + PLEN_W'(1);
			addr_q    <= {addr_q[ADDR_W-2:0], 1'b0};
			hit_q     <= hit_n;
			hit_reg_q <= reg_n;
		end
		if (do_alloc) begin
			node_q    <= '0;
			use_rd_q  <= 1'b0;
			cur_idx_q <= new_idx;
			level_q   <= level_q + PLEN_W'(1);
			addr_q    <= {addr_q[ADDR_W-2:0], 1'b0};
		end
		if (finish) begin
			res_q <= res_n;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

`ifndef SYNTH
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q >= FREE_W'(1)) && (next_free_q <= FREE_W'(NODE_COUNT)))
		else $error("free pointer out of range");

	a_free_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != $past(next_free_q)) |->
		($past(state_q) == ST_WALK && $past(op_q) == lpt_pkg::OP_INSERT))
		else $error("free pointer moved outside an insert walk");

	a_rd_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && use_rd_q) |-> (cur_idx_q != '0))
		else $error("root taken from node memory");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (level_q <= limit_q))
		else $error("walk went past its depth limit");

	a_ovf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.overflow) |-> (!rsp_q.found && rsp_q.match_region == '0))
		else $error("overflow beat carries a match");
`endif

endmodule
